### rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants for the tilt safety supervisor
// Mode codes, register map, reset values, controller states and the
// hall commutation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_TRIP_ANGLE    = 3'd0;
    localparam logic [2:0] REG_RECOVER_ANGLE = 3'd1;
    localparam logic [2:0] REG_STOP_WAIT     = 3'd2;
    localparam logic [2:0] REG_STUCK_WAIT    = 3'd3;
    localparam logic [2:0] REG_MAX_ATTEMPTS  = 3'd4;
    localparam logic [2:0] REG_GAIN          = 3'd5;
    localparam logic [2:0] REG_ALPHA         = 3'd6;
    localparam logic [2:0] REG_MAX_PWM       = 3'd7;

    localparam logic [14:0] TRIP_ANGLE_RST    = 15'd35;
    localparam logic [14:0] RECOVER_ANGLE_RST = 15'd2;
    localparam logic [15:0] STOP_WAIT_RST     = 16'd500;
    localparam logic [15:0] STUCK_WAIT_RST    = 16'd50;
    localparam logic [2:0]  MAX_ATTEMPTS_RST  = 3'd3;
    localparam logic [7:0]  GAIN_RST          = 8'd179;
    localparam logic [7:0]  ALPHA_RST         = 8'd0;
    localparam logic [15:0] MAX_PWM_RST       = 16'd1000;

    localparam logic [2:0] HALL_NONE = 3'd0;
    localparam logic [1:0] STEP_FWD  = 2'b01;
    localparam logic [1:0] STEP_REV  = 2'b11;
    localparam logic [1:0] STEP_ZERO = 2'b00;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_STOP     = 2'd1,
        MODE_RECOVERY = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HALL,
        ST_SUPER,
        ST_MIX_A,
        ST_MIX_B,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [14:0] trip_angle;
        logic [14:0] recover_angle;
        logic [15:0] stop_wait_ms;
        logic [15:0] stuck_wait_ms;
        logic [2:0]  max_attempts;
        logic [7:0]  recovery_gain_q8;
        logic [7:0]  smoothing_alpha_q8;
        logic [15:0] max_pwm;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic hall_en;
        logic super_en;
        logic mix_a_en;
        logic mix_b_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic drive_req;
        logic out_busy;
    } dp_status_t;

    // forward successor of each hall code, HALL_NONE where there is none
    function automatic logic [2:0] hall_fwd_next(input logic [2:0] code);
        logic [2:0] nxt;
        case (code)
            3'd1:    nxt = 3'd5;
            3'd2:    nxt = 3'd3;
            3'd3:    nxt = 3'd1;
            3'd4:    nxt = 3'd6;
            3'd5:    nxt = 3'd4;
            3'd6:    nxt = 3'd2;
            default: nxt = HALL_NONE;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

### rtl/tss_regs.sv
// ----------------------------------------------------------------------------
// tss_regs: configuration register bank
// APB-style write and read access to the eight supervisor settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tss_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tss_pkg::DATA_W-1:0] pwdata,
    output logic      [tss_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output tss_pkg::cfg_t                   cfg
);
    import tss_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_angle         <= TRIP_ANGLE_RST;
            cfg_reg.recover_angle      <= RECOVER_ANGLE_RST;
            cfg_reg.stop_wait_ms       <= STOP_WAIT_RST;
            cfg_reg.stuck_wait_ms      <= STUCK_WAIT_RST;
            cfg_reg.max_attempts       <= MAX_ATTEMPTS_RST;
            cfg_reg.recovery_gain_q8   <= GAIN_RST;
            cfg_reg.smoothing_alpha_q8 <= ALPHA_RST;
            cfg_reg.max_pwm            <= MAX_PWM_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TRIP_ANGLE:    cfg_reg.trip_angle         <= pwdata[14:0];
                REG_RECOVER_ANGLE: cfg_reg.recover_angle      <= pwdata[14:0];
                REG_STOP_WAIT:     cfg_reg.stop_wait_ms       <= pwdata[15:0];
                REG_STUCK_WAIT:    cfg_reg.stuck_wait_ms      <= pwdata[15:0];
                REG_MAX_ATTEMPTS:  cfg_reg.max_attempts       <= pwdata[2:0];
                REG_GAIN:          cfg_reg.recovery_gain_q8   <= pwdata[7:0];
                REG_ALPHA:         cfg_reg.smoothing_alpha_q8 <= pwdata[7:0];
                REG_MAX_PWM:       cfg_reg.max_pwm            <= pwdata[15:0];
                default:           cfg_reg.max_pwm            <= cfg_reg.max_pwm;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TRIP_ANGLE:    prdata = {17'd0, cfg_reg.trip_angle};
            REG_RECOVER_ANGLE: prdata = {17'd0, cfg_reg.recover_angle};
            REG_STOP_WAIT:     prdata = {16'd0, cfg_reg.stop_wait_ms};
            REG_STUCK_WAIT:    prdata = {16'd0, cfg_reg.stuck_wait_ms};
            REG_MAX_ATTEMPTS:  prdata = {29'd0, cfg_reg.max_attempts};
            REG_GAIN:          prdata = {24'd0, cfg_reg.recovery_gain_q8};
            REG_ALPHA:         prdata = {24'd0, cfg_reg.smoothing_alpha_q8};
            REG_MAX_PWM:       prdata = {16'd0, cfg_reg.max_pwm};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl: tick sequencer
// Walks one word through hall decode, supervisor, PWM mixing (when a motor write is requested) and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tss_pkg::dp_status_t  status,
    output tss_pkg::dp_cmd_t          cmd
);
    import tss_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_HALL;
                end
            end
            ST_HALL:
            begin
                cmd.hall_en = 1'b1;
                state_next  = ST_SUPER;
            end
            ST_SUPER:
            begin
                cmd.super_en = 1'b1;
                state_next   = status.drive_req ? ST_MIX_A : ST_DONE;
            end
            ST_MIX_A:
            begin
                cmd.mix_a_en = 1'b1;
                state_next   = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                cmd.mix_b_en = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/tss_dp.sv
// ----------------------------------------------------------------------------
// tss_dp: supervisor datapath
// Hall step counter, mode and timer state, recovery drive scaling,
// PWM smoothing and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tss_pkg::cfg_t      cfg,
    input  wire tss_pkg::dp_cmd_t   cmd,
    output tss_pkg::dp_status_t     status,
    input  wire logic signed [15:0] tilt_angle,
    input  wire logic        [2:0]  hall_code,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic             [1:0]  mode,
    output logic                    motor_write,
    output logic             [15:0] pwm_magnitude,
    output logic                    motor_reverse,
    output logic signed      [1:0]  hall_step,
    output logic signed      [31:0] hall_position,
    output logic             [2:0]  attempts_used,
    output logic                    recovered,
    output logic signed      [34:0] home_angle,
    output logic                    stuck_drive
);
    import tss_pkg::*;

    // persistent state
    mode_t       mode_reg,      mode_next;
    logic [31:0] time_reg;
    logic [31:0] stop_time_reg, stop_time_next;
    logic [31:0] rec_start_reg, rec_start_next;
    logic [2:0]  attempt_reg,   attempt_next;
    logic [31:0] pos_reg;
    logic [31:0] snap_reg,      snap_next;
    logic [2:0]  prev_code_reg;
    logic        seen_reg;
    logic [15:0] smooth_reg;

    // per-word working registers
    logic        tilt_neg_reg;
    logic [15:0] mag_reg;
    logic [2:0]  code_reg;
    logic [23:0] prod_reg;
    logic [31:0] elapsed_reg;
    logic [1:0]  step_reg;
    logic        wr_reg,    wr_next;
    logic        rev_reg,   rev_next;
    logic        rec_reg,   rec_next;
    logic        stuck_reg, stuck_next;
    logic [34:0] home_reg,  home_next;
    logic [15:0] raw_reg,   raw_next;
    logic [23:0] acc_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_mode_reg;
    logic        out_wr_reg;
    logic [15:0] out_pwm_reg;
    logic        out_rev_reg;
    logic [1:0]  out_step_reg;
    logic [31:0] out_pos_reg;
    logic [2:0]  out_att_reg;
    logic        out_rec_reg;
    logic [34:0] out_home_reg;
    logic        out_stuck_reg;

    logic [15:0] tilt_u;
    logic [15:0] mag_in;
    logic [15:0] drive_mag;
    logic [8:0]  alpha_inv;
    logic [24:0] mix_sum;
    logic        drive_req;

    assign tilt_u    = tilt_angle;
    assign mag_in    = tilt_u[15] ? (~tilt_u + 16'd1) : tilt_u;
    assign drive_mag = prod_reg[23:8];
    assign alpha_inv = 9'd256 - {1'b0, cfg.smoothing_alpha_q8};
    assign mix_sum   = {1'b0, acc_reg} + (25'(alpha_inv) * 25'(smooth_reg));

    // word capture, hall decode and per-word arithmetic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg <= HALL_NONE;
            seen_reg      <= 1'b0;
            pos_reg       <= '0;
            step_reg      <= STEP_ZERO;
        end
        else if (cmd.hall_en)
        begin
            step_reg <= STEP_ZERO;
            if (!seen_reg)
            begin
                prev_code_reg <= code_reg;
                seen_reg      <= 1'b1;
            end
            else if (hall_fwd_next(prev_code_reg) == code_reg && code_reg != HALL_NONE)
            begin
                pos_reg       <= pos_reg + 32'd1;
                prev_code_reg <= code_reg;
                step_reg      <= STEP_FWD;
            end
            else if (hall_fwd_next(code_reg) == prev_code_reg && prev_code_reg != HALL_NONE)
            begin
                pos_reg       <= pos_reg - 32'd1;
                prev_code_reg <= code_reg;
                step_reg      <= STEP_REV;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tilt_neg_reg <= tilt_angle[15];
            mag_reg      <= mag_in;
            code_reg     <= hall_code;
        end
        if (cmd.hall_en)
        begin
            prod_reg    <= 24'(cfg.recovery_gain_q8) * 24'(mag_reg);
            elapsed_reg <= time_reg - ((mode_reg == MODE_STOP) ? stop_time_reg
                                                                : rec_start_reg);
        end
        if (cmd.super_en)
        begin
            wr_reg    <= wr_next;
            rev_reg   <= rev_next;
            rec_reg   <= rec_next;
            stuck_reg <= stuck_next;
            home_reg  <= home_next;
            raw_reg   <= raw_next;
        end
        if (cmd.mix_a_en)
        begin
            acc_reg <= 24'(cfg.smoothing_alpha_q8) * 24'(raw_reg);
        end
    end

    // supervisor decision
    always_comb
    begin
        mode_next      = mode_reg;
        stop_time_next = stop_time_reg;
        rec_start_next = rec_start_reg;
        attempt_next   = attempt_reg;
        snap_next      = snap_reg;
        wr_next        = 1'b0;
        rev_next       = 1'b0;
        rec_next       = 1'b0;
        stuck_next     = 1'b0;
        home_next      = '0;
        raw_next       = '0;
        case (mode_reg)
            MODE_NORMAL:
            begin
                if (mag_reg >= {1'b0, cfg.trip_angle})
                begin
                    mode_next      = MODE_STOP;
                    stop_time_next = time_reg;
                    wr_next        = 1'b1;
                    rev_next       = 1'b1;
                end
            end
            MODE_STOP:
            begin
                if (elapsed_reg >= {16'd0, cfg.stop_wait_ms} &&
                    attempt_reg < cfg.max_attempts)
                begin
                    mode_next      = MODE_RECOVERY;
                    rec_start_next = time_reg;
                    attempt_next   = attempt_reg + 3'd1;
                    snap_next      = pos_reg;
                end
            end
            MODE_RECOVERY:
            begin
                if (mag_reg < {1'b0, cfg.recover_angle})
                begin
                    mode_next    = MODE_NORMAL;
                    attempt_next = '0;
                    rec_next     = 1'b1;
                    home_next    = {pos_reg, 3'b000};
                end
                else if (elapsed_reg > {16'd0, cfg.stuck_wait_ms} && snap_reg == pos_reg)
                begin
                    wr_next    = 1'b1;
                    stuck_next = 1'b1;
                    raw_next   = (drive_mag > cfg.max_pwm) ? cfg.max_pwm : drive_mag;
                    rev_next   = !(cfg.recovery_gain_q8 != 8'd0 && tilt_neg_reg);
                end
            end
            default:
            begin
                mode_next = MODE_STOP;
            end
        endcase
    end

    assign drive_req = wr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            time_reg      <= '0;
            stop_time_reg <= '0;
            rec_start_reg <= '0;
            attempt_reg   <= '0;
            snap_reg      <= '0;
            smooth_reg    <= '0;
        end
        else
        begin
            if (cmd.super_en)
            begin
                mode_reg      <= mode_next;
                time_reg      <= time_reg + 32'd1;
                stop_time_reg <= stop_time_next;
                rec_start_reg <= rec_start_next;
                attempt_reg   <= attempt_next;
                snap_reg      <= snap_next;
            end
            if (cmd.mix_b_en)
            begin
                if (cfg.smoothing_alpha_q8 == 8'd0)
                begin
                    smooth_reg <= raw_reg;
                end
                else
                begin
                    smooth_reg <= mix_sum[23:8];
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mode_reg  <= mode_reg;
            out_wr_reg    <= wr_reg;
            out_pwm_reg   <= wr_reg ? smooth_reg : 16'd0;
            out_rev_reg   <= rev_reg;
            out_step_reg  <= step_reg;
            out_pos_reg   <= pos_reg;
            out_att_reg   <= attempt_reg;
            out_rec_reg   <= rec_reg;
            out_home_reg  <= home_reg;
            out_stuck_reg <= stuck_reg;
        end
    end

    assign status.drive_req = drive_req;
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign mode          = out_mode_reg;
    assign motor_write   = out_wr_reg;
    assign pwm_magnitude = out_pwm_reg;
    assign motor_reverse = out_rev_reg;
    assign hall_step     = out_step_reg;
    assign hall_position = out_pos_reg;
    assign attempts_used = out_att_reg;
    assign recovered     = out_rec_reg;
    assign home_angle    = out_home_reg;
    assign stuck_drive   = out_stuck_reg;

endmodule

`default_nettype wire

### rtl/tilt_safety_supervisor_hall_counter.sv
// ----------------------------------------------------------------------------
// tilt_safety_supervisor_hall_counter: tilt safety supervisor with hall counter
// Sequencing: out_valid is registered after the sequencer steps through hall
// decode, supervisor and output; the mix A and mix B states are added for the
// smoothing multiplies when a motor command is written. A new word is taken
// once the last is loaded; a stalled result holds the sequencer until it drains.
// Reset: rst_n clears mode, timers, counters and settings to defaults at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_safety_supervisor_hall_counter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tss_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tss_pkg::DATA_W-1:0] pwdata,
    output logic      [tss_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [15:0]         tilt_angle,
    input  wire logic        [2:0]          hall_code,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic             [1:0]          mode,
    output logic                            motor_write,
    output logic             [15:0]         pwm_magnitude,
    output logic                            motor_reverse,
    output logic signed      [1:0]          hall_step,
    output logic signed      [31:0]         hall_position,
    output logic             [2:0]          attempts_used,
    output logic                            recovered,
    output logic signed      [34:0]         home_angle,
    output logic                            stuck_drive
);
    import tss_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    tss_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tss_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .tilt_angle    (tilt_angle),
        .hall_code     (hall_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mode          (mode),
        .motor_write   (motor_write),
        .pwm_magnitude (pwm_magnitude),
        .motor_reverse (motor_reverse),
        .hall_step     (hall_step),
        .hall_position (hall_position),
        .attempts_used (attempts_used),
        .recovered     (recovered),
        .home_angle    (home_angle),
        .stuck_drive   (stuck_drive)
    );

endmodule

`default_nettype wire
